@@ sv/prefix_tree_count_engine_top_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef PREFIX_TREE_COUNT_ENGINE_TOP_MACROS_SVH
`define PREFIX_TREE_COUNT_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, muted while reset is high.
`define PTCE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, muted while reset is high.
`define PTCE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ sv/ptce_pkg.sv @@
`default_nettype none
package ptce_pkg;

   localparam int NODE_COUNT_DEF   = 1024;
   localparam int ALPHABET_DEF     = 26;
   localparam int MAX_WORD_LEN_DEF = 32;

   localparam int LETTER_W = 5;
   localparam int COUNT_W  = 10;
   localparam int STATUS_W = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_COUNT  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_POOL_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LONG  = 2'd2;

   typedef struct packed {
      logic                op;
      logic [LETTER_W-1:0] letter;
      logic                last;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  word_count;
      logic                newly_added;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef enum logic [7:0] {
      S_CLEAR  = 8'b0000_0001,
      S_IDLE   = 8'b0000_0010,
      S_LOOK   = 8'b0000_0100,
      S_FIN    = 8'b0000_1000,
      S_WALK_A = 8'b0001_0000,
      S_WALK_B = 8'b0010_0000,
      S_WALK_C = 8'b0100_0000,
      S_RESP   = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic look;
      logic fin;
      logic walk_a;
      logic walk_b;
      logic walk_c;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic last;
      logic need_walk;
      logic walk_done;
      logic rsp_free;
   } sts_type;

endpackage
`default_nettype wire

@@ sv/prefix_tree_count_engine_top.sv @@
// Channel | Direction | Handshake            | Word
// req     | in        | req_valid/req_ready  | ptce_pkg::req_type (op, letter, last)
// rsp     | out       | rsp_valid/rsp_ready  | ptce_pkg::rsp_type (word_count, newly_added, status)
//
// Each letter passes through an accept step, which reads the child link, and a
// lookup step, which follows or creates it. A last letter adds a finish step
// that reads the end mark or count, walk steps A, B and C per path node when a
// new word's counts go up, and a response step that loads the output register.
// After reset a clearing pass zeroes all NODE_COUNT*ALPHABET link table entries
// (26624 at the defaults), with req_ready low.
// A stalled rsp holds its word; the engine waits in its response step until
// the output register frees, and req_ready stays low meanwhile.
`default_nettype none
module prefix_tree_count_engine_top #(
   parameter int NODE_COUNT   = ptce_pkg::NODE_COUNT_DEF,
   parameter int ALPHABET     = ptce_pkg::ALPHABET_DEF,
   parameter int MAX_WORD_LEN = ptce_pkg::MAX_WORD_LEN_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ptce_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ptce_pkg::rsp_type rsp_data
);

   // command and status between sequencer and datapath
   ptce_pkg::cmd_type cmd;
   ptce_pkg::sts_type sts;

   // sequencer: clear pass, letter lookup, word finish, count walk, respond
   ptce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .sts       (sts),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   // datapath: link table, counts, end marks, path buffer, output register
   ptce_dp #(
      .NODE_COUNT   (NODE_COUNT),
      .ALPHABET     (ALPHABET),
      .MAX_WORD_LEN (MAX_WORD_LEN)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

@@ sv/ptce_ctrl.sv @@
`default_nettype none
module ptce_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  ptce_pkg::sts_type sts,
   output logic              req_ready,
   output ptce_pkg::cmd_type cmd
);

   ptce_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ptce_pkg::S_CLEAR:  if (sts.clear_done) state_in = ptce_pkg::S_IDLE;
         ptce_pkg::S_IDLE:   if (req_valid) state_in = ptce_pkg::S_LOOK;
         ptce_pkg::S_LOOK:   state_in = sts.last ? ptce_pkg::S_FIN : ptce_pkg::S_IDLE;
         ptce_pkg::S_FIN:    state_in = sts.need_walk ? ptce_pkg::S_WALK_A : ptce_pkg::S_RESP;
         ptce_pkg::S_WALK_A: state_in = ptce_pkg::S_WALK_B;
         ptce_pkg::S_WALK_B: state_in = ptce_pkg::S_WALK_C;
         ptce_pkg::S_WALK_C: state_in = sts.walk_done ? ptce_pkg::S_RESP : ptce_pkg::S_WALK_A;
         ptce_pkg::S_RESP:   if (sts.rsp_free) state_in = ptce_pkg::S_IDLE;
         default:            state_in = ptce_pkg::S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptce_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready   = (state_ff == ptce_pkg::S_IDLE);
   assign cmd.clear   = (state_ff == ptce_pkg::S_CLEAR);
   assign cmd.accept  = (state_ff == ptce_pkg::S_IDLE) && req_valid;
   assign cmd.look    = (state_ff == ptce_pkg::S_LOOK);
   assign cmd.fin     = (state_ff == ptce_pkg::S_FIN);
   assign cmd.walk_a  = (state_ff == ptce_pkg::S_WALK_A);
   assign cmd.walk_b  = (state_ff == ptce_pkg::S_WALK_B);
   assign cmd.walk_c  = (state_ff == ptce_pkg::S_WALK_C);
   assign cmd.respond = (state_ff == ptce_pkg::S_RESP) && sts.rsp_free;

endmodule
`default_nettype wire

@@ sv/ptce_dp.sv @@
`default_nettype none
module ptce_dp #(
   parameter int NODE_COUNT   = ptce_pkg::NODE_COUNT_DEF,
   parameter int ALPHABET     = ptce_pkg::ALPHABET_DEF,
   parameter int MAX_WORD_LEN = ptce_pkg::MAX_WORD_LEN_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  ptce_pkg::cmd_type cmd,
   input  ptce_pkg::req_type req_data,
   input  logic              rsp_ready,
   output ptce_pkg::sts_type sts,
   output logic              rsp_valid,
   output ptce_pkg::rsp_type rsp_data
);

   localparam int NODE_W     = $clog2(NODE_COUNT);
   localparam int SYM_W      = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
   localparam int LINK_DEPTH = NODE_COUNT * ALPHABET;
   localparam int LINK_AW    = $clog2(LINK_DEPTH);
   localparam int PLEN_W     = $clog2(MAX_WORD_LEN + 1);
   localparam int PATH_AW    = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
   localparam int CW         = ptce_pkg::COUNT_W;
   localparam int SW         = ptce_pkg::STATUS_W;

   // storage
   logic [NODE_W-1:0] link_mem [LINK_DEPTH];
   logic [CW-1:0]     pc_mem   [NODE_COUNT];
   logic              em_mem   [NODE_COUNT];
   logic [NODE_W-1:0] path_mem [MAX_WORD_LEN];
   logic [NODE_W-1:0] link_q_ff, path_q_ff;
   logic [CW-1:0]     pc_q_ff;
   logic              em_q_ff;

   // control and word state
   logic [LINK_AW-1:0] clear_cnt_ff, clear_cnt_in;
   logic               in_word_ff, in_word_in;
   logic               op_ff, op_in;
   logic               last_ff, last_in;
   logic [LINK_AW-1:0] slot_ff, slot_in;
   logic [NODE_W-1:0]  cursor_ff, cursor_in;
   logic [NODE_W:0]    next_free_ff, next_free_in;
   logic [PLEN_W-1:0]  path_len_ff, path_len_in;
   logic               created_ff, created_in;
   logic               missing_ff, missing_in;
   logic               error_ff, error_in;
   logic [SW-1:0]      err_code_ff, err_code_in;
   logic [PLEN_W-1:0]  walk_idx_ff, walk_idx_in;
   logic [NODE_W-1:0]  walk_node_ff, walk_node_in;
   logic [CW-1:0]      res_count_ff, res_count_in;
   logic               res_added_ff, res_added_in;
   logic [SW-1:0]      res_status_ff, res_status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   ptce_pkg::rsp_type  rsp_ff, rsp_in;

   // memory ports
   logic               link_we;
   logic [LINK_AW-1:0] link_waddr, link_raddr;
   logic [NODE_W-1:0]  link_wdata;
   logic               pc_we;
   logic [NODE_W-1:0]  pc_waddr, pc_raddr;
   logic [CW-1:0]      pc_wdata;
   logic               em_we;
   logic [NODE_W-1:0]  em_waddr;
   logic               em_wdata;
   logic               path_we;
   logic [PATH_AW-1:0] path_raddr;

   logic [8:0]         letter_x;
   logic [SYM_W-1:0]   sym;
   logic               word_op;
   logic [NODE_W-1:0]  new_node;
   logic               rsp_free;
   logic               walk_needed;

   assign letter_x = 9'(req_data.letter);
   assign sym = (letter_x >= 9'(ALPHABET)) ? SYM_W'(ALPHABET - 1) : SYM_W'(letter_x);
   assign word_op  = in_word_ff ? op_ff : req_data.op;
   assign new_node = next_free_ff[NODE_W-1:0];
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign walk_needed = (op_ff == ptce_pkg::OP_INSERT) && !error_ff && (created_ff || !em_q_ff);

   always_comb begin
      clear_cnt_in  = clear_cnt_ff;
      in_word_in    = in_word_ff;
      op_in         = op_ff;
      last_in       = last_ff;
      slot_in       = slot_ff;
      cursor_in     = cursor_ff;
      next_free_in  = next_free_ff;
      path_len_in   = path_len_ff;
      created_in    = created_ff;
      missing_in    = missing_ff;
      error_in      = error_ff;
      err_code_in   = err_code_ff;
      walk_idx_in   = walk_idx_ff;
      walk_node_in  = walk_node_ff;
      res_count_in  = res_count_ff;
      res_added_in  = res_added_ff;
      res_status_in = res_status_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      link_we    = 1'b0;
      link_waddr = slot_ff;
      link_wdata = new_node;
      link_raddr = LINK_AW'(cursor_ff) * LINK_AW'(ALPHABET) + LINK_AW'(sym);
      pc_we      = 1'b0;
      pc_waddr   = new_node;
      pc_wdata   = '0;
      pc_raddr   = cursor_ff;
      em_we      = 1'b0;
      em_waddr   = new_node;
      em_wdata   = 1'b0;
      path_we    = 1'b0;
      path_raddr = walk_idx_ff[PATH_AW-1:0];

      if (cmd.clear) begin
         link_we      = 1'b1;
         link_waddr   = clear_cnt_ff;
         link_wdata   = '0;
         clear_cnt_in = LINK_AW'(clear_cnt_ff + LINK_AW'(1));
      end

      if (cmd.accept) begin
         in_word_in = 1'b1;
         op_in      = word_op;
         last_in    = req_data.last;
         slot_in    = link_raddr;
      end

      if (cmd.look) begin
         if (op_ff == ptce_pkg::OP_INSERT) begin
            if (!error_ff) begin
               if (path_len_ff >= PLEN_W'(MAX_WORD_LEN)) begin
                  error_in    = 1'b1;
                  err_code_in = ptce_pkg::STATUS_TOO_LONG;
               end else if (link_q_ff == '0) begin
                  if (next_free_ff >= (NODE_W+1)'(NODE_COUNT)) begin
                     error_in    = 1'b1;
                     err_code_in = ptce_pkg::STATUS_POOL_FULL;
                  end else begin
                     // create the child and zero its count and mark
                     link_we      = 1'b1;
                     pc_we        = 1'b1;
                     em_we        = 1'b1;
                     path_we      = 1'b1;
                     cursor_in    = new_node;
                     next_free_in = (NODE_W+1)'(next_free_ff + (NODE_W+1)'(1));
                     path_len_in  = PLEN_W'(path_len_ff + PLEN_W'(1));
                     created_in   = 1'b1;
                  end
               end else begin
                  path_we     = 1'b1;
                  cursor_in   = link_q_ff;
                  path_len_in = PLEN_W'(path_len_ff + PLEN_W'(1));
               end
            end
         end else if (!missing_ff) begin
            if (link_q_ff == '0) begin
               missing_in = 1'b1;
            end else begin
               cursor_in = link_q_ff;
            end
         end
         pc_raddr = cursor_in;
      end

      if (cmd.fin) begin
         res_count_in  = '0;
         res_added_in  = 1'b0;
         res_status_in = ptce_pkg::STATUS_OK;
         walk_idx_in   = '0;
         if (op_ff == ptce_pkg::OP_INSERT) begin
            if (error_ff) begin
               res_status_in = err_code_ff;
            end else if (walk_needed) begin
               em_we        = 1'b1;
               em_waddr     = cursor_ff;
               em_wdata     = 1'b1;
               res_added_in = 1'b1;
            end
         end else if (!missing_ff) begin
            res_count_in = pc_q_ff;
         end
      end

      if (cmd.walk_b) begin
         walk_node_in = path_q_ff;
         pc_raddr     = path_q_ff;
      end

      if (cmd.walk_c) begin
         pc_we       = 1'b1;
         pc_waddr    = walk_node_ff;
         pc_wdata    = (pc_q_ff == ptce_pkg::COUNT_MAX) ? pc_q_ff : CW'(pc_q_ff + CW'(1));
         walk_idx_in = PLEN_W'(walk_idx_ff + PLEN_W'(1));
      end

      if (cmd.respond) begin
         rsp_in.word_count  = res_count_ff;
         rsp_in.newly_added = res_added_ff;
         rsp_in.status      = res_status_ff;
         rsp_valid_in       = 1'b1;
         // drop the word context
         in_word_in  = 1'b0;
         cursor_in   = '0;
         path_len_in = '0;
         created_in  = 1'b0;
         missing_in  = 1'b0;
         error_in    = 1'b0;
         err_code_in = ptce_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) link_mem[link_waddr] <= link_wdata;
      link_q_ff <= link_mem[link_raddr];
   end

   always_ff @(posedge clock) begin
      if (pc_we) pc_mem[pc_waddr] <= pc_wdata;
      pc_q_ff <= pc_mem[pc_raddr];
   end

   always_ff @(posedge clock) begin
      if (em_we) em_mem[em_waddr] <= em_wdata;
      em_q_ff <= em_mem[cursor_in];
   end

   always_ff @(posedge clock) begin
      if (path_we) path_mem[path_len_ff[PATH_AW-1:0]] <= cursor_in;
      path_q_ff <= path_mem[path_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
         in_word_ff   <= 1'b0;
         cursor_ff    <= '0;
         next_free_ff <= (NODE_W+1)'(1);
         path_len_ff  <= '0;
         created_ff   <= 1'b0;
         missing_ff   <= 1'b0;
         error_ff     <= 1'b0;
         err_code_ff  <= ptce_pkg::STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         clear_cnt_ff <= clear_cnt_in;
         in_word_ff   <= in_word_in;
         cursor_ff    <= cursor_in;
         next_free_ff <= next_free_in;
         path_len_ff  <= path_len_in;
         created_ff   <= created_in;
         missing_ff   <= missing_in;
         error_ff     <= error_in;
         err_code_ff  <= err_code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      last_ff       <= last_in;
      slot_ff       <= slot_in;
      walk_idx_ff   <= walk_idx_in;
      walk_node_ff  <= walk_node_in;
      res_count_ff  <= res_count_in;
      res_added_ff  <= res_added_in;
      res_status_ff <= res_status_in;
      rsp_ff        <= rsp_in;
   end

   assign sts.clear_done = (clear_cnt_ff == LINK_AW'(LINK_DEPTH - 1));
   assign sts.last       = last_ff;
   assign sts.need_walk  = walk_needed;
   assign sts.walk_done  = (PLEN_W'(walk_idx_ff + PLEN_W'(1)) == path_len_ff);
   assign sts.rsp_free   = rsp_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

@@ sv/ptce_checker.sv @@
`default_nettype none
`include "prefix_tree_count_engine_top_macros.svh"
module ptce_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ptce_pkg::rsp_type rsp_data
);

   `PTCE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `PTCE_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data))
   `PTCE_ASSERT_NEXT(a_letter_gap, clock, reset, req_valid && req_ready, !req_ready)
   `PTCE_ASSERT_NOW(a_err_clean, clock, reset, rsp_valid && rsp_data.status != ptce_pkg::STATUS_OK, rsp_data.word_count == '0 && !rsp_data.newly_added)

endmodule

bind prefix_tree_count_engine_top ptce_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire
